>>> hw/rtl/hcl_pkg.sv
// Package: transaction types, front classification record and name constants.
`timescale 1ns / 1ps

package hcl_pkg;

  localparam int NameLen    = 15;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_response;
  } rx_item_t;

  typedef struct packed {
    logic        complete;
    logic        headers_done;
    logic        length_known;
    logic [31:0] length_value;
    logic [31:0] body_received;
    logic        length_overflow;
  } status_item_t;

  typedef struct packed {
    logic       start;
    logic [7:0] lc;
    logic       is_c;
    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SPACES = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_KNOWN  = 4'b1000
  } phase_t;

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/hcl_front.sv
// Front stage: accept a byte transaction, classify it and register the result.
`timescale 1ns / 1ps

module hcl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            rx_valid,
  output logic            rx_ready,
  input  hcl_pkg::rx_item_t rx_item,
  output logic            cls_valid,
  input  logic            cls_ready,
  output hcl_pkg::cls_t   cls
);
  import hcl_pkg::*;

  cls_t       cls_next;
  logic [7:0] b;

  assign rx_ready = !cls_valid || cls_ready;
  assign b        = rx_item.data_byte;

  always_comb begin
    cls_next.start    = rx_item.start_of_response;
    cls_next.lc       = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    cls_next.is_c     = (cls_next.lc == name_char(4'd0));
    cls_next.is_space = (b == ChSpace);
    cls_next.is_digit = (b >= "0" && b <= "9");
    cls_next.digit    = 4'(b - "0");
    cls_next.is_cr    = (b == ChCr);
    cls_next.is_lf    = (b == ChLf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (rx_ready) begin
      cls_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      cls <= cls_next;
    end
  end

endmodule

>>> hw/rtl/hcl_queue.sv
// Short queue of classified bytes between the front and back stages.
`timescale 1ns / 1ps

module hcl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  hcl_pkg::cls_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hcl_pkg::cls_t pop_item
);
  import hcl_pkg::*;

  cls_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != (QueuePtrW + 1)'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/hcl_back.sv
// Back stage: parser state, length accumulator, terminator and body counters.
`timescale 1ns / 1ps

module hcl_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cls_valid,
  output logic                  cls_ready,
  input  hcl_pkg::cls_t         cls,
  output logic                  status_valid,
  input  logic                  status_ready,
  output hcl_pkg::status_item_t status_item
);
  import hcl_pkg::*;

  logic [3:0]             pos;
  phase_t                 phase;
  logic [LENGTH_BITS-1:0] accum;
  logic                   ovf;
  logic [1:0]             tp;
  logic                   hdr;
  logic [31:0]            body;

  logic [3:0]             pos_next;
  phase_t                 phase_next;
  logic [LENGTH_BITS-1:0] accum_next;
  logic                   ovf_next;
  logic [1:0]             tp_next;
  logic                   hdr_next;
  logic [31:0]            body_next;
  status_item_t           status_next;

  logic [3:0]             idx;
  logic [3:0]             pos_inc;
  logic [LENGTH_BITS+3:0] wide;
  logic [63:0]            accum_ext;
  logic                   take;

  assign take      = cls_valid && cls_ready;
  assign cls_ready = !status_valid || status_ready;

  always_comb begin
    if (cls.start) begin
      pos_next   = '0;
      phase_next = PH_SEARCH;
      accum_next = '0;
      ovf_next   = 1'b0;
      tp_next    = '0;
      hdr_next   = 1'b0;
      body_next  = '0;
    end else begin
      pos_next   = pos;
      phase_next = phase;
      accum_next = accum;
      ovf_next   = ovf;
      tp_next    = tp;
      hdr_next   = hdr;
      body_next  = body;
    end

    idx     = (pos_next == 4'(NameLen)) ? 4'd0 : pos_next;
    pos_inc = idx + 4'd1;
    wide    = ({4'b0, accum_next} << 3) + ({4'b0, accum_next} << 1)
              + (LENGTH_BITS + 4)'(cls.digit);

    if (hdr_next) begin
      if (body_next != '1) begin
        body_next = body_next + 32'd1;
      end
    end else begin
      unique case (phase_next) inside
        PH_SEARCH: begin
          if (cls.lc == name_char(idx)) begin
            if (pos_inc == 4'(NameLen)) begin
              phase_next = PH_SPACES;
              pos_next   = '0;
            end else begin
              pos_next = pos_inc;
            end
          end else begin
            pos_next = cls.is_c ? 4'd1 : 4'd0;
          end
        end
        PH_SPACES, PH_DIGITS: begin
          if (phase_next == PH_SPACES && cls.is_space) begin
            phase_next = PH_SPACES;
          end else if (cls.is_digit) begin
            if (ovf_next || (wide[LENGTH_BITS+3:LENGTH_BITS] != '0)) begin
              accum_next = '1;
              ovf_next   = 1'b1;
            end else begin
              accum_next = wide[LENGTH_BITS-1:0];
            end
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_KNOWN;
          end
        end
        PH_KNOWN: begin
          phase_next = PH_KNOWN;
        end
        default: begin
          phase_next = PH_SEARCH;
        end
      endcase

      if (cls.is_cr) begin
        tp_next = (tp_next == 2'd2) ? 2'd3 : 2'd1;
      end else if (cls.is_lf) begin
        if (tp_next == 2'd1) begin
          tp_next = 2'd2;
        end else if (tp_next == 2'd3) begin
          tp_next  = 2'd0;
          hdr_next = 1'b1;
        end else begin
          tp_next = 2'd0;
        end
      end else begin
        tp_next = 2'd0;
      end

      if (hdr_next) begin
        pos_next = '0;
      end
    end

    accum_ext                   = 64'(accum_next);
    status_next.headers_done    = hdr_next;
    status_next.length_known    = (phase_next == PH_KNOWN);
    status_next.length_value    = accum_ext[31:0];
    status_next.body_received   = body_next;
    status_next.length_overflow = ovf_next;
    status_next.complete        = hdr_next && (phase_next == PH_KNOWN) && !ovf_next
                                  && (64'(body_next) == accum_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      phase        <= PH_SEARCH;
      accum        <= '0;
      ovf          <= 1'b0;
      tp           <= '0;
      hdr          <= 1'b0;
      body         <= '0;
      status_valid <= 1'b0;
    end else begin
      if (take) begin
        pos   <= pos_next;
        phase <= phase_next;
        accum <= accum_next;
        ovf   <= ovf_next;
        tp    <= tp_next;
        hdr   <= hdr_next;
        body  <= body_next;
      end
      if (cls_ready) begin
        status_valid <= cls_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_item <= status_next;
    end
  end

endmodule

>>> hw/rtl/http_content_length_completion_top.sv
// Top level: HTTP Content-Length message end detector.
//
// Usage: feed the response one byte per rx transaction, with
// start_of_response set on the first byte of each response to clear all
// parser state. Every accepted byte yields exactly one status transaction
// showing the state after that byte: headers_done after CR LF CR LF,
// length_known once the Content-Length number has ended, the parsed length
// (saturated, with length_overflow) and the body byte count. complete is
// high on the byte where the body count equals the length.
// Each byte passes the front register, the queue and the status register.
// Throughput: one byte per cycle unless the status receiver stalls, set by
// the back stage's per-byte update; a four-entry queue of classified bytes
// sits between the classifier and the back stage.
// Reset (rst, synchronous) empties the pipeline and clears parser state.
// When the status receiver stalls, the output register holds its item,
// the queue fills, and rx_ready falls once the queue and front register
// are full; nothing is dropped.
`timescale 1ns / 1ps

module http_content_length_completion_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  output logic                  rx_ready,
  input  hcl_pkg::rx_item_t     rx_item,
  output logic                  status_valid,
  input  logic                  status_ready,
  output hcl_pkg::status_item_t status_item
);
  import hcl_pkg::*;

  logic f_valid;
  logic f_ready;
  cls_t f_cls;
  logic q_valid;
  logic q_ready;
  cls_t q_cls;

  hcl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_item   (rx_item),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls       (f_cls)
  );

  hcl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_cls)
  );

  hcl_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (q_valid),
    .cls_ready    (q_ready),
    .cls          (q_cls),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status_item  (status_item)
  );

endmodule

>>> hw/rtl/hcl_checker.sv
// Checker: port-level properties of the detector, bound to the top level.
`timescale 1ns / 1ps

module hcl_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  rx_valid,
  input logic                  rx_ready,
  input hcl_pkg::rx_item_t     rx_item,
  input logic                  status_valid,
  input logic                  status_ready,
  input hcl_pkg::status_item_t status_item
);

  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid && $stable(status_item))
    else $error("status transaction changed while stalled");

  a_complete_flags: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_item.complete |->
      status_item.headers_done && status_item.length_known &&
      !status_item.length_overflow)
    else $error("complete without headers_done, length_known or with overflow");

  a_complete_count: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_item.complete |->
      status_item.body_received == status_item.length_value)
    else $error("complete with body count not equal to length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !status_valid)
    else $error("status valid right after reset");

endmodule

bind http_content_length_completion_top hcl_checker u_hcl_checker (.*);
